### rtl/mbe_pkg.sv
// shared types, constants and helpers of the escape-time engine
package mbe_pkg;

    localparam int unsigned JOB_DEPTH = 2;
    localparam int unsigned JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    localparam int unsigned FRAC_BITS = 26;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_REAL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IMAG      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT   = 3'd5;

    localparam logic signed [31:0] RST_ORIGIN_REAL    = 32'shF800_0000; // -2.0
    localparam logic signed [31:0] RST_ORIGIN_IMAG    = 32'shFA00_0000; // -1.5
    localparam logic signed [31:0] RST_STEP_REAL      = 32'sd251658;
    localparam logic signed [31:0] RST_STEP_IMAG      = 32'sd251658;
    localparam logic [10:0]        RST_ITERATION_LIMIT = 11'd30;
    localparam logic [31:0]        RST_ESCAPE_LIMIT   = 32'h0800_0000; // 2.0

    typedef struct packed {
        logic signed [31:0] origin_real;
        logic signed [31:0] origin_imag;
        logic signed [31:0] step_real;
        logic signed [31:0] step_imag;
        logic [10:0]        iteration_limit;
        logic [31:0]        escape_limit;
    } t_cfg;

    typedef struct packed {
        logic [9:0] column;
        logic [9:0] row;
    } t_pixel;

    typedef struct packed {
        logic [9:0]  out_column;
        logic [9:0]  out_row;
        logic [10:0] iteration_count;
        logic        in_set;
        logic [31:0] magnitude_squared;
    } t_result;

    typedef struct packed {
        logic [9:0]         column;
        logic [9:0]         row;
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
    } t_job;

    // clamp a wide signed sum to the signed 32-bit range
    function automatic logic signed [31:0] sat_s32(input logic signed [43:0] v);
        logic signed [31:0] res;
        if (v > 44'sh7FFF_FFFF)
            res = 32'sh7FFF_FFFF;
        else if (v < -44'sh8000_0000)
            res = 32'sh8000_0000;
        else
            res = v[31:0];
        return res;
    endfunction

endpackage

### rtl/mbe_front.sv
// front end: takes pixel beats and forms the point c for each
module mbe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbe_pkg::t_cfg  i_cfg,
    input  logic           push,
    input  mbe_pkg::t_pixel i_pixel,
    output logic           full,
    output logic           o_job_push,
    output mbe_pkg::t_job  o_job,
    input  logic           i_job_full
);
    import mbe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ADD  = 4'b0100,
        S_PUSH = 4'b1000
    } t_front_state;

    t_front_state r_state, n_state;

    logic [9:0]         r_col, r_row;
    logic signed [42:0] r_p_re, r_p_im;
    logic signed [31:0] r_c_re, r_c_im;

    logic signed [42:0] w_p_re, w_p_im;
    logic signed [43:0] w_s_re, w_s_im;

    assign w_p_re = $signed({1'b0, r_col}) * i_cfg.step_real;
    assign w_p_im = $signed({1'b0, r_row}) * i_cfg.step_imag;
    assign w_s_re = 44'(i_cfg.origin_real) + 44'(r_p_re);
    assign w_s_im = 44'(i_cfg.origin_imag) + 44'(r_p_im);

    assign full       = (r_state != S_IDLE);
    assign o_job_push = (r_state == S_PUSH) && !i_job_full;
    assign o_job      = '{column: r_col, row: r_row, c_re: r_c_re, c_im: r_c_im};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (push) n_state = S_MUL;
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = S_PUSH;
            S_PUSH: if (!i_job_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (push) begin
                r_col <= i_pixel.column;
                r_row <= i_pixel.row;
            end
            S_MUL: begin
                r_p_re <= w_p_re;
                r_p_im <= w_p_im;
            end
            S_ADD: begin
                r_c_re <= sat_s32(w_s_re);
                r_c_im <= sat_s32(w_s_im);
            end
            default: ;
        endcase
    end

    a_push_from_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> $past(r_state == S_ADD) || $past(r_state == S_PUSH))
        else $error("job pushed without a finished c");

endmodule

### rtl/mbe_job_fifo.sv
// short job queue between front end and iteration engine
module mbe_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mbe_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output mbe_pkg::t_job o_job,
    output logic          o_empty
);
    import mbe_pkg::*;

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [JOB_CNT_W-1:0] r_count;

    logic w_wr, w_rd;

    assign o_full  = (r_count == JOB_CNT_W'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    function automatic logic [JOB_PTR_W-1:0] ptr_inc(input logic [JOB_PTR_W-1:0] p);
        logic [JOB_PTR_W-1:0] res;
        if (p == JOB_PTR_W'(JOB_DEPTH - 1))
            res = '0;
        else
            res = p + 1'b1;
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (w_rd) r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (w_wr && !w_rd)
                r_count <= r_count + 1'b1;
            else if (w_rd && !w_wr)
                r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= i_job;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= JOB_CNT_W'(JOB_DEPTH))
        else $error("job queue over capacity");

endmodule

### rtl/mbe_iter.sv
// iteration engine: z = z*z + c on one shared multiplier, plus result register
module mbe_iter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mbe_pkg::t_cfg   i_cfg,
    input  mbe_pkg::t_job   i_job,
    input  logic            i_job_empty,
    output logic            o_job_pop,
    output mbe_pkg::t_result o_result,
    output logic            empty,
    input  logic            pop
);
    import mbe_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UPDATE = 7'b0000010,
        S_MUL_RR = 7'b0000100,
        S_MUL_II = 7'b0001000,
        S_MUL_RI = 7'b0010000,
        S_CHECK  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_iter_state;

    t_iter_state r_state, n_state;

    logic [9:0]         r_col, r_row;
    logic signed [31:0] r_c_re, r_c_im;
    logic signed [31:0] r_zr, r_zi;
    logic signed [63:0] r_prod;
    logic signed [37:0] r_sr, r_si;
    logic signed [38:0] r_x;
    logic [31:0]        r_mag;
    logic [10:0]        r_count;
    logic               r_out_valid;
    t_result            r_out;

    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod;
    logic signed [37:0] w_sq;
    logic signed [38:0] w_cross;
    logic signed [43:0] w_re_sum, w_im_sum;
    logic [38:0]        w_mag_sum;
    logic [31:0]        w_mag;
    logic               w_escape;
    logic [10:0]        w_count_inc;
    logic               w_take;
    logic               w_out_load;

    always_comb begin
        unique case (r_state)
            S_MUL_RR: begin w_mul_a = r_zr; w_mul_b = r_zr; end
            S_MUL_II: begin w_mul_a = r_zi; w_mul_b = r_zi; end
            S_MUL_RI: begin w_mul_a = r_zr; w_mul_b = r_zi; end
            default:  begin w_mul_a = '0;   w_mul_b = '0;   end
        endcase
    end

    assign w_prod    = 64'(w_mul_a) * 64'(w_mul_b);
    assign w_sq      = r_prod[63:FRAC_BITS];
    assign w_cross   = r_prod[63:FRAC_BITS-1];
    assign w_re_sum  = 44'(r_sr) - 44'(r_si) + 44'(r_c_re);
    assign w_im_sum  = 44'(r_x) + 44'(r_c_im);
    assign w_mag_sum = 39'(r_sr) + 39'(r_si);
    assign w_mag     = (|w_mag_sum[38:32]) ? 32'hFFFF_FFFF : w_mag_sum[31:0];
    assign w_escape  = (w_mag >= i_cfg.escape_limit);
    assign w_count_inc = r_count + 11'd1;

    assign w_take     = (r_state == S_IDLE) && !i_job_empty;
    assign o_job_pop  = w_take;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || pop);
    assign empty      = !r_out_valid;
    assign o_result   = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_take) begin
                n_state = (i_cfg.iteration_limit == '0) ? S_DONE : S_UPDATE;
            end
            S_UPDATE: n_state = S_MUL_RR;
            S_MUL_RR: n_state = S_MUL_II;
            S_MUL_II: n_state = S_MUL_RI;
            S_MUL_RI: n_state = S_CHECK;
            S_CHECK: begin
                if (w_escape || (w_count_inc == i_cfg.iteration_limit))
                    n_state = S_DONE;
                else
                    n_state = S_UPDATE;
            end
            S_DONE: if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load)
                r_out_valid <= 1'b1;
            else if (pop)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (w_take) begin
                r_col   <= i_job.column;
                r_row   <= i_job.row;
                r_c_re  <= i_job.c_re;
                r_c_im  <= i_job.c_im;
                r_sr    <= '0;
                r_si    <= '0;
                r_x     <= '0;
                r_mag   <= '0;
                r_count <= '0;
            end
            S_UPDATE: begin
                r_zr <= sat_s32(w_re_sum);
                r_zi <= sat_s32(w_im_sum);
            end
            S_MUL_RR: r_prod <= w_prod;
            S_MUL_II: begin
                r_sr   <= w_sq;
                r_prod <= w_prod;
            end
            S_MUL_RI: begin
                r_si   <= w_sq;
                r_prod <= w_prod;
            end
            S_CHECK: begin
                r_x   <= w_cross;
                r_mag <= w_mag;
                if (!w_escape) r_count <= w_count_inc;
            end
            S_DONE: if (w_out_load) begin
                r_out <= '{out_column:        r_col,
                           out_row:           r_row,
                           iteration_count:   r_count,
                           in_set:            (r_count == i_cfg.iteration_limit),
                           magnitude_squared: r_mag};
            end
            default: ;
        endcase
    end

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result shown without a finished pixel");

    a_check_exits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |=> (r_state == S_UPDATE || r_state == S_DONE))
        else $error("bad exit from escape check");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CHECK && r_state != S_IDLE) |=> $stable(r_count))
        else $error("iteration count moved outside the check step");

endmodule

### rtl/mandelbrot_escape_time_core.sv
// top level of the escape-time engine: config registers, front end, queue, iterator
//
// usage
//   pixel side: drive i_pixel and raise push; a beat is taken on a clock edge
//   with push high and full low. result side: while empty is low the oldest
//   result sits on o_result; raise pop to take it on that edge.
//   config side: i_cfg_index / i_cfg_data with i_cfg_valid; o_cfg_ready is
//   always high. write only while no pixel is in flight.
// timing
//   front end forms c in its multiply and add steps, then the job waits
//   in a 2-deep queue. each iteration uses the one shared 32x32 multiplier
//   in the steps update, three products and escape check, and the back
//   end sets throughput unless a held result register stalls it.
// reset
//   synchronous active-low reset empties queue and result register and loads
//   the default view (-2.0 - 1.5i origin, 30 iterations, escape limit 2.0).
// stall
//   a full result register parks the back end in its done state; the queue
//   then fills and full rises, without losing any beat.
module mandelbrot_escape_time_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    input  mbe_pkg::t_pixel                i_pixel,
    output logic                           full,
    output logic                           empty,
    input  logic                           pop,
    output mbe_pkg::t_result               o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import mbe_pkg::*;

    // view and limit registers
    t_cfg r_cfg;

    // front end to queue
    logic w_job_push;
    t_job w_front_job;
    logic w_job_full;

    // queue to iterator
    t_job w_iter_job;
    logic w_job_empty;
    logic w_job_pop;

    // config channel never back-pressures
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_real     <= RST_ORIGIN_REAL;
            r_cfg.origin_imag     <= RST_ORIGIN_IMAG;
            r_cfg.step_real       <= RST_STEP_REAL;
            r_cfg.step_imag       <= RST_STEP_IMAG;
            r_cfg.iteration_limit <= RST_ITERATION_LIMIT;
            r_cfg.escape_limit    <= RST_ESCAPE_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_REAL:     r_cfg.origin_real     <= i_cfg_data;
                CFG_ORIGIN_IMAG:     r_cfg.origin_imag     <= i_cfg_data;
                CFG_STEP_REAL:       r_cfg.step_real       <= i_cfg_data;
                CFG_STEP_IMAG:       r_cfg.step_imag       <= i_cfg_data;
                CFG_ITERATION_LIMIT: r_cfg.iteration_limit <= i_cfg_data[10:0];
                CFG_ESCAPE_LIMIT:    r_cfg.escape_limit    <= i_cfg_data;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // c = origin + index * step, one pixel at a time
    mbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .push       (push),
        .i_pixel    (i_pixel),
        .full       (full),
        .o_job_push (w_job_push),
        .o_job      (w_front_job),
        .i_job_full (w_job_full)
    );

    // decouples the front end from the long-running iterator
    mbe_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_front_job),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_job   (w_iter_job),
        .o_empty (w_job_empty)
    );

    // escape-time loop and result register
    mbe_iter u_iter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (w_iter_job),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
